FILE: hw/rtl/sssc_pkg.sv
package sssc_pkg;

  localparam int unsigned MaxSamples = 256;
  localparam int unsigned IdxW       = $clog2(MaxSamples + 1);
  localparam int unsigned StartW     = $clog2(MaxSamples);
  localparam int unsigned CoordW     = 12;
  localparam int unsigned SumW       = 20;
  localparam int unsigned WidthW     = 9;
  localparam int unsigned ThrW       = 8;
  localparam int unsigned DimW       = 11;
  localparam int unsigned MeanW      = 11;
  localparam int unsigned RemW       = WidthW + 1;
  localparam int unsigned DivCntW    = $clog2(SumW);
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 32;

  typedef enum logic [AddrW-1:0] {
    RegThreshold = 5'd0,
    RegMinWidth  = 5'd4,
    RegMaxWidth  = 5'd8,
    RegImgWidth  = 5'd12,
    RegImgHeight = 5'd16
  } reg_addr_e;

  typedef enum logic [2:0] {
    StRun  = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

FILE: hw/rtl/scanline_single_segment_centroid_unit.sv
// Scan-line centroid unit for one painted road line.
// The input channel (in_valid_i / in_stall_o) takes one sample item per cycle
// while in_stall_o is low: pixel value, signed x and y, and a last-sample flag.
// A sample that is not the last one is absorbed and yields no result.
// The last sample of a scan closes it. With exactly one run of accepted width,
// both mean coordinates are computed by one shared restoring divider that
// produces one quotient bit per cycle, first x then y; after the y quotient the
// done state loads the result into the output register. Without a match the
// scan goes straight to the done state, which loads the all-zero result.
// Until then in_stall_o is high; right after, the next scan may start.
// The output channel (out_valid_o / out_stall_i) is held in a register; while
// the receiver stalls, the result holds and new samples are still taken; a
// further last sample is taken too, after which the input stalls until the
// register has been emptied.
// The APB port writes the five configuration registers at byte addresses 0,
// 4, 8, 12 and 16; it is to be written only between scans.
// Reset clears the scan state, empties the output register and loads the
// default configuration.
module scanline_single_segment_centroid_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sssc_pkg::AddrW-1:0]       paddr,
  input  logic [sssc_pkg::DataW-1:0]       pwdata,
  output logic [sssc_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       in_pixel_value_i,
  input  logic signed [sssc_pkg::CoordW-1:0] in_sample_x_i,
  input  logic signed [sssc_pkg::CoordW-1:0] in_sample_y_i,
  input  logic                             in_last_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             out_matched_o,
  output logic [sssc_pkg::MeanW-1:0]       out_mean_x_o,
  output logic [sssc_pkg::MeanW-1:0]       out_mean_y_o,
  output logic [sssc_pkg::StartW-1:0]      out_match_start_o,
  output logic [sssc_pkg::WidthW-1:0]      out_match_width_o
);

  localparam int unsigned SumW   = sssc_pkg::SumW;
  localparam int unsigned WidthW = sssc_pkg::WidthW;
  localparam int unsigned RemW   = sssc_pkg::RemW;
  localparam int unsigned IdxW   = sssc_pkg::IdxW;
  localparam int unsigned StartW = sssc_pkg::StartW;
  localparam int unsigned DimW   = sssc_pkg::DimW;
  localparam int unsigned MeanW  = sssc_pkg::MeanW;
  localparam int unsigned CntW   = sssc_pkg::DivCntW;

  logic [sssc_pkg::ThrW-1:0] thr_q;
  logic [WidthW-1:0]         min_w_q, max_w_q;
  logic [DimW-1:0]           img_w_q, img_h_q;

  logic                      cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      min_w_q <= WidthW'(1);
      max_w_q <= WidthW'(256);
      img_w_q <= DimW'(640);
      img_h_q <= DimW'(480);
    end else if (cfg_wr) begin
      unique case (paddr)
        sssc_pkg::RegThreshold: thr_q   <= pwdata[sssc_pkg::ThrW-1:0];
        sssc_pkg::RegMinWidth:  min_w_q <= pwdata[WidthW-1:0];
        sssc_pkg::RegMaxWidth:  max_w_q <= pwdata[WidthW-1:0];
        sssc_pkg::RegImgWidth:  img_w_q <= pwdata[DimW-1:0];
        sssc_pkg::RegImgHeight: img_h_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      sssc_pkg::RegThreshold: prdata = sssc_pkg::DataW'(thr_q);
      sssc_pkg::RegMinWidth:  prdata = sssc_pkg::DataW'(min_w_q);
      sssc_pkg::RegMaxWidth:  prdata = sssc_pkg::DataW'(max_w_q);
      sssc_pkg::RegImgWidth:  prdata = sssc_pkg::DataW'(img_w_q);
      sssc_pkg::RegImgHeight: prdata = sssc_pkg::DataW'(img_h_q);
      default:                prdata = '0;
    endcase
  end

  sssc_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]   idx_q, idx_d;
  logic              in_run_q, in_run_d;
  logic [1:0]        rc_q, rc_d;
  logic [StartW-1:0] start_q, start_d;
  logic [WidthW-1:0] wid_q, wid_d;
  logic [SumW-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;

  logic              in_acc, active, rc_inc, first_open, ok;
  logic [DimW-1:0]   x_u, y_u;

  assign in_stall_o = (state_q != sssc_pkg::StRun);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign x_u        = in_sample_x_i[DimW-1:0];
  assign y_u        = in_sample_y_i[DimW-1:0];

  always_comb begin
    active = !in_sample_x_i[sssc_pkg::CoordW-1] && !in_sample_y_i[sssc_pkg::CoordW-1] &&
             (x_u < img_w_q) && (y_u < img_h_q) && (in_pixel_value_i > thr_q) &&
             (idx_q < IdxW'(sssc_pkg::MaxSamples));
    rc_inc     = active && !in_run_q;
    first_open = rc_inc && (rc_q == 2'd0);
    start_d    = first_open ? idx_q[StartW-1:0] : start_q;
    rc_d       = (rc_inc && rc_q != 2'd2) ? rc_q + 2'd1 : rc_q;
    wid_d      = first_open ? '0 : wid_q;
    sum_x_d    = first_open ? '0 : sum_x_q;
    sum_y_d    = first_open ? '0 : sum_y_q;
    if (active && rc_d == 2'd1) begin
      wid_d   = wid_d + WidthW'(1);
      sum_x_d = sum_x_d + SumW'(x_u);
      sum_y_d = sum_y_d + SumW'(y_u);
    end
    in_run_d = active;
    idx_d    = (idx_q < IdxW'(sssc_pkg::MaxSamples)) ? idx_q + IdxW'(1) : idx_q;
    ok       = (rc_d == 2'd1) && (wid_d != '0) && (wid_d >= min_w_q) && (wid_d <= max_w_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      in_run_q <= 1'b0;
      rc_q     <= '0;
      start_q  <= '0;
      wid_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
    end else if (in_acc) begin
      if (in_last_sample_i) begin
        idx_q    <= '0;
        in_run_q <= 1'b0;
        rc_q     <= '0;
        start_q  <= '0;
        wid_q    <= '0;
        sum_x_q  <= '0;
        sum_y_q  <= '0;
      end else begin
        idx_q    <= idx_d;
        in_run_q <= in_run_d;
        rc_q     <= rc_d;
        start_q  <= start_d;
        wid_q    <= wid_d;
        sum_x_q  <= sum_x_d;
        sum_y_q  <= sum_y_d;
      end
    end
  end

  // Shared restoring divider: one quotient bit per cycle, x then y.
  logic [SumW-1:0]   dvd_q, hold_y_q;
  logic [RemW-1:0]   rem_q, shifted;
  logic [WidthW-1:0] dsr_q;
  logic [CntW-1:0]   cnt_q;
  logic              sel_y_q;
  logic [RemW:0]     trial;
  logic              ge;
  logic [SumW-1:0]   dvd_next;

  logic              res_m_q;
  logic [MeanW-1:0]  res_x_q, res_y_q;
  logic [StartW-1:0] res_s_q;
  logic [WidthW-1:0] res_w_q;
  logic              out_valid_q;
  logic              out_free;

  assign shifted  = {rem_q[RemW-2:0], dvd_q[SumW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge       = !trial[RemW];
  assign dvd_next = {dvd_q[SumW-2:0], ge};
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sssc_pkg::StRun: begin
        if (in_acc && in_last_sample_i) state_d = ok ? sssc_pkg::StDiv : sssc_pkg::StDone;
      end
      sssc_pkg::StDiv: begin
        if (sel_y_q && cnt_q == CntW'(SumW - 1)) state_d = sssc_pkg::StDone;
      end
      sssc_pkg::StDone: begin
        if (out_free) state_d = sssc_pkg::StRun;
      end
      default: state_d = sssc_pkg::StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sssc_pkg::StRun;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sssc_pkg::StRun && in_acc && in_last_sample_i) begin
      dvd_q    <= sum_x_d;
      hold_y_q <= sum_y_d;
      rem_q    <= '0;
      dsr_q    <= wid_d;
      cnt_q    <= '0;
      sel_y_q  <= 1'b0;
      res_m_q  <= ok;
      res_s_q  <= ok ? start_d : '0;
      res_w_q  <= ok ? wid_d : '0;
      res_x_q  <= '0;
      res_y_q  <= '0;
    end else if (state_q == sssc_pkg::StDiv) begin
      if (cnt_q == CntW'(SumW - 1)) begin
        if (sel_y_q) begin
          res_y_q <= dvd_next[MeanW-1:0];
        end else begin
          res_x_q <= dvd_next[MeanW-1:0];
          dvd_q   <= hold_y_q;
          rem_q   <= '0;
          cnt_q   <= '0;
          sel_y_q <= 1'b1;
        end
      end else begin
        dvd_q <= dvd_next;
        rem_q <= ge ? trial[RemW-1:0] : shifted;
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == sssc_pkg::StDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sssc_pkg::StDone && out_free) begin
      out_matched_o     <= res_m_q;
      out_mean_x_o      <= res_x_q;
      out_mean_y_o      <= res_y_q;
      out_match_start_o <= res_s_q;
      out_match_width_o <= res_w_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_unmatched_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_matched_o) |-> (out_mean_x_o == '0 && out_mean_y_o == '0 &&
      out_match_start_o == '0 && out_match_width_o == '0))
    else $error("unmatched result carries nonzero fields");

  a_matched_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_matched_o) |-> (out_match_width_o != '0))
    else $error("matched result with zero width");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sssc_pkg::StDiv) |-> (dsr_q != '0))
    else $error("divide started with zero divisor");

endmodule
